// ===== rtl/pila_pkg.sv =====
// shared types and constants for the pin interrupt line allocator
package pila_pkg;

  localparam int PORT_W = 4;
  localparam int PIN_W  = 4;
  localparam int LINE_W = 4;
  localparam int MODE_W = 2;
  localparam int PIN_CNT = 16;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } scan_state_t;

  // one table entry as read back
  typedef struct packed {
    logic              used;
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
  } entry_t;

  // table write request
  typedef struct packed {
    logic              en;
    logic              used;
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
  } entry_wr_t;

endpackage

// ===== rtl/pila_table.sv =====
// line table: port/pin memory with registered read and flop used bits
module pila_table import pila_pkg::*; #(
  parameter int NUM_LINES = 16,
  parameter int IW        = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd,
  input  entry_wr_t     wr,
  input  logic [IW-1:0] wr_addr
);

  logic [PORT_W+PIN_W-1:0] mem [NUM_LINES];
  logic [NUM_LINES-1:0]    used;
  logic [PORT_W+PIN_W-1:0] rd_data;
  logic                    rd_used;

  assign rd = {rd_used, rd_data};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr.port, wr.pin};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // used bits clear at reset, so never-written entries read as free
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      rd_used <= 1'b0;
    end else begin
      if (wr.en) begin
        used[wr_addr] <= wr.used;
      end
      if (rd_en) begin
        rd_used <= used[rd_addr];
      end
    end
  end

endmodule

// ===== rtl/pila_scan.sv =====
// sequencer: walks the group's lines through one compare unit, then writes back a found line
module pila_scan import pila_pkg::*; #(
  parameter int NUM_LINES       = 16,
  parameter int LINES_PER_GROUP = 4,
  parameter int IW              = 4,
  parameter int EW              = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PORT_W-1:0] req_port,
  input  logic [PIN_W-1:0]  req_pin,
  input  logic              req_enable,
  input  logic [MODE_W-1:0] req_mode,
  input  logic [EW-1:0]     base,
  output logic              busy,
  output logic              rd_en,
  output logic [IW-1:0]     rd_addr,
  input  entry_t            rd,
  output entry_wr_t         wr,
  output logic [IW-1:0]     wr_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic [LINE_W-1:0] line,
  output logic              line_valid,
  output logic              rising_enable,
  output logic              falling_enable
);

  localparam int KW = $clog2(LINES_PER_GROUP + 1);

  scan_state_t       state;
  logic [PORT_W-1:0] port_q;
  logic [PIN_W-1:0]  pin_q;
  logic              enable_q;
  logic [MODE_W-1:0] mode_q;
  logic [EW-1:0]     base_q;
  logic [KW-1:0]     k;
  logic              pend;
  logic [EW-1:0]     pend_idx;
  logic              match_found;
  logic [EW-1:0]     match_idx;
  logic              free_found;
  logic [EW-1:0]     free_idx;

  logic [EW-1:0] idx;
  logic          issue_ok;
  logic          hit;
  logic          found;
  logic [EW-1:0] sel_idx;
  logic          leave;
  logic          rise;
  logic          fall;

  assign idx      = base_q + EW'(k);
  assign issue_ok = (k < KW'(LINES_PER_GROUP)) && (idx < EW'(NUM_LINES));
  assign hit      = rd.used && (rd.port == port_q) && (rd.pin == pin_q);
  assign found    = match_found || free_found;
  assign sel_idx  = match_found ? match_idx : free_idx;
  assign leave    = (state == S_WRITE) && (!out_valid || !out_stall);
  assign rise     = mode_q[0];
  assign fall     = mode_q[1];

  assign busy    = (state != S_IDLE);
  assign rd_en   = (state == S_SCAN) && issue_ok;
  assign rd_addr = idx[IW-1:0];

  always_comb begin
    wr.en   = leave && found;
    wr.used = enable_q;
    wr.port = enable_q ? port_q : '0;
    wr.pin  = enable_q ? pin_q : '0;
    wr_addr = sel_idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      pend        <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      // a word taken in the same cycle as a new one is loaded stays valid
      if (out_valid && !out_stall && !leave) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            port_q      <= req_port;
            pin_q       <= req_pin;
            enable_q    <= req_enable;
            mode_q      <= req_mode;
            base_q      <= base;
            k           <= '0;
            pend        <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= issue_ok;
          pend_idx <= idx;
          if (issue_ok) begin
            k <= k + KW'(1);
          end
          // read data comes back in the cycle after its address is issued
          if (pend) begin
            if (hit && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= pend_idx;
            end
            if (!rd.used && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pend_idx;
            end
          end
          if (!issue_ok && !pend) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (leave) begin
            out_valid      <= 1'b1;
            status         <= !found && enable_q;
            line           <= found ? sel_idx[LINE_W-1:0] : '0;
            line_valid     <= found;
            // full group on enable reports no edges
            rising_enable  <= rise && (found || !enable_q);
            falling_enable <= fall && (found || !enable_q);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pin_interrupt_line_allocator.sv =====
// one word at a time: in_stall stays high until the result is loaded
// into the output register; the group scan does one table read per cycle
// reset (rst, synchronous): all lines unused, no result pending
module pin_interrupt_line_allocator import pila_pkg::*; #(
  parameter int NUM_LINES       = 16,
  parameter int LINES_PER_GROUP = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PORT_W-1:0] port,
  input  logic [PIN_W-1:0]  pin,
  input  logic              enable,
  input  logic [MODE_W-1:0] edge_mode,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic [LINE_W-1:0] line,
  output logic              line_valid,
  output logic              rising_enable,
  output logic              falling_enable
);

  localparam int IW = $clog2(NUM_LINES);
  localparam int EW = $clog2(NUM_LINES + PIN_CNT + LINES_PER_GROUP);

  logic [EW-1:0] base_tab [PIN_CNT];
  logic          busy;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd;
  entry_wr_t     wr;
  logic [IW-1:0] wr_addr;

  // first line of each pin's group, fixed at elaboration
  for (genvar p = 0; p < PIN_CNT; p++) begin : g_base
    assign base_tab[p] = EW'((p / LINES_PER_GROUP) * LINES_PER_GROUP);
  end

  assign in_stall = busy;

  pila_scan #(
    .NUM_LINES       (NUM_LINES),
    .LINES_PER_GROUP (LINES_PER_GROUP),
    .IW              (IW),
    .EW              (EW)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .start          (in_valid && !busy),
    .req_port       (port),
    .req_pin        (pin),
    .req_enable     (enable),
    .req_mode       (edge_mode),
    .base           (base_tab[pin]),
    .busy           (busy),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd             (rd),
    .wr             (wr),
    .wr_addr        (wr_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .line           (line),
    .line_valid     (line_valid),
    .rising_enable  (rising_enable),
    .falling_enable (falling_enable)
  );

  pila_table #(
    .NUM_LINES (NUM_LINES),
    .IW        (IW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd      (rd),
    .wr      (wr),
    .wr_addr (wr_addr)
  );

endmodule

// ===== rtl/pila_checker.sv =====
// port-level checks for the pin interrupt line allocator, bound to the top level
module pila_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       status,
  input logic [3:0] line,
  input logic       line_valid,
  input logic       rising_enable,
  input logic       falling_enable
);

  // one word in flight: an accepted word blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line) && $stable(status))
    else $error("stalled result changed");

  a_full_no_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !line_valid && line == 4'd0)
    else $error("full group reported with a line");

  a_full_no_edges: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !rising_enable && !falling_enable)
    else $error("full group reported with edge enables");

  a_invalid_line_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_valid |-> line == 4'd0)
    else $error("line not zero while not valid");

endmodule

bind pin_interrupt_line_allocator pila_checker u_pila_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .line           (line),
  .line_valid     (line_valid),
  .rising_enable  (rising_enable),
  .falling_enable (falling_enable)
);

// ===== test/line_grant_checker.sv =====
// predicts and checks the words of the pin interrupt line allocator
module line_grant_checker import pila_pkg::*; #(
  parameter int NUM_LINES       = 16,
  parameter int LINES_PER_GROUP = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [PORT_W-1:0] port,
  input  logic [PIN_W-1:0]  pin,
  input  logic              enable,
  input  logic [MODE_W-1:0] edge_mode,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              status,
  input  logic [LINE_W-1:0] line,
  input  logic              line_valid,
  input  logic              rising_enable,
  input  logic              falling_enable,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
  localparam int   SHOW_MAX    = 10;

  typedef struct packed {
    logic              status;
    logic [LINE_W-1:0] line;
    logic              line_valid;
    logic              rise;
    logic              fall;
  } grant_t;

  entry_t line_map [NUM_LINES];
  grant_t grant_q [$];
  int     misses;
  int     checked;
  int     refused;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    full_seen    = 0;
    misses       = 0;
    checked      = 0;
    refused      = 0;
  end

  // search the pin's group, update the map, return the expected word
  function automatic grant_t allocate_line(input logic [PORT_W-1:0] p,
                                           input logic [PIN_W-1:0]  n,
                                           input logic              en,
                                           input logic [MODE_W-1:0] m);
    grant_t g;
    int     base;
    int     idx;
    int     pick;
    bit     have;
    bit     hit;
    base = (int'(n) / LINES_PER_GROUP) * LINES_PER_GROUP;
    have = 0;
    hit  = 0;
    pick = 0;
    for (int k = 0; k < LINES_PER_GROUP; k++) begin
      idx = base + k;
      // lines past the end of the table do not exist
      if (idx < NUM_LINES && !hit) begin
        if (line_map[idx].used && line_map[idx].port == p && line_map[idx].pin == n) begin
          hit  = 1;
          pick = idx;
        end else if (!have && !line_map[idx].used) begin
          have = 1;
          pick = idx;
        end
      end
    end
    if (!(hit || have)) begin
      // group full: a map is refused, a release only echoes the edges
      g.status     = en ? STATUS_FULL : STATUS_OK;
      g.line       = '0;
      g.line_valid = 1'b0;
      g.rise       = en ? 1'b0 : m[0];
      g.fall       = en ? 1'b0 : m[1];
    end else begin
      line_map[pick].used = en;
      line_map[pick].port = en ? p : '0;
      line_map[pick].pin  = en ? n : '0;
      g.status     = STATUS_OK;
      g.line       = pick[LINE_W-1:0];
      g.line_valid = 1'b1;
      g.rise       = m[0];
      g.fall       = m[1];
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (rst) begin
      for (int i = 0; i < NUM_LINES; i++) line_map[i] = '0;
      grant_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status, line, line_valid, rising_enable, falling_enable};
        checked++;
        if (grant_q.size() == 0) begin
          misses++;
          if (misses <= SHOW_MAX)
            $display("%0t: unexpected word status=%0d line=%0d valid=%0d rise=%0d fall=%0d",
                     $realtime, got.status, got.line, got.line_valid, got.rise, got.fall);
        end else begin
          want = grant_q.pop_front();
          if (got !== want) begin
            misses++;
            if (misses <= SHOW_MAX)
              $display({"%0t: mismatch exp status=%0d line=%0d valid=%0d rise=%0d fall=%0d",
                        " got status=%0d line=%0d valid=%0d rise=%0d fall=%0d"},
                       $realtime, want.status, want.line, want.line_valid, want.rise,
                       want.fall, got.status, got.line, got.line_valid, got.rise, got.fall);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = allocate_line(port, pin, enable, edge_mode);
        if (want.status == STATUS_FULL) refused++;
        grant_q.push_back(want);
      end
    end
    pending      <= grant_q.size();
    fail_count   <= misses;
    results_seen <= checked;
    full_seen    <= refused;
  end

endmodule

// ===== test/pin_interrupt_line_allocator_test.sv =====
// stimulus, handshake pacing and verdict for the pin interrupt line allocator
module pin_interrupt_line_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pila_pkg::*;

  localparam int NUM_LINES       = 16;
  localparam int LINES_PER_GROUP = 4;
  localparam int RANDOM_WORDS    = 1080;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_LIMIT      = 5000;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RISE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FALL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH = 2'd3;
  localparam logic              REQ_MAP   = 1'b1;
  localparam logic              REQ_FREE  = 1'b0;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [PORT_W-1:0] port;
  logic [PIN_W-1:0]  pin;
  logic              enable;
  logic [MODE_W-1:0] edge_mode;
  logic              out_valid;
  logic              out_stall;
  logic              status;
  logic [LINE_W-1:0] line;
  logic              line_valid;
  logic              rising_enable;
  logic              falling_enable;

  int fail_count;
  int pending;
  int results_seen;
  int full_seen;
  int words_sent;
  int idle_cycles;
  bit steady;
  bit hold_done;

  pin_interrupt_line_allocator #(
    .NUM_LINES      (NUM_LINES),
    .LINES_PER_GROUP(LINES_PER_GROUP)
  ) i_dut (.*);

  line_grant_checker #(
    .NUM_LINES      (NUM_LINES),
    .LINES_PER_GROUP(LINES_PER_GROUP)
  ) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one, none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [PORT_W-1:0] p, input logic [PIN_W-1:0] n,
                           input logic en, input logic [MODE_W-1:0] m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    port      <= p;
    pin       <= n;
    enable    <= en;
    edge_mode <= m;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  initial begin
    logic [PORT_W-1:0] p;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    port       <= '0;
    pin        <= '0;
    enable     <= 1'b0;
    edge_mode  <= MODE_NONE;
    words_sent = 0;
    steady     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(4'd0,  4'd0,  REQ_MAP,  MODE_NONE);
    send_word(4'd15, 4'd15, REQ_MAP,  MODE_BOTH);
    send_word(4'd15, 4'd15, REQ_MAP,  MODE_RISE);  // same pin keeps its line
    send_word(4'd3,  4'd13, REQ_MAP,  MODE_FALL);
    send_word(4'd7,  4'd14, REQ_MAP,  MODE_BOTH);
    send_word(4'd9,  4'd12, REQ_MAP,  MODE_RISE);
    send_word(4'd5,  4'd15, REQ_MAP,  MODE_BOTH);  // last group full, refused
    send_word(4'd5,  4'd15, REQ_FREE, MODE_FALL);  // release with nothing to find
    send_word(4'd3,  4'd13, REQ_FREE, MODE_RISE);
    send_word(4'd5,  4'd15, REQ_MAP,  MODE_NONE);  // takes the freed line
    send_word(4'd0,  4'd6,  REQ_FREE, MODE_BOTH);  // release lands on a free line
    send_word(4'd0,  4'd0,  REQ_FREE, MODE_NONE);
    send_word(4'd10, 4'd5,  REQ_MAP,  MODE_FALL);
    send_word(4'd10, 4'd5,  REQ_FREE, MODE_RISE);
    send_word(4'd15, 4'd15, REQ_FREE, MODE_NONE);
    send_word(4'd5,  4'd15, REQ_FREE, MODE_BOTH);
    send_word(4'd7,  4'd14, REQ_FREE, MODE_FALL);
    send_word(4'd9,  4'd12, REQ_FREE, MODE_RISE);

    // few ports in play so groups fill up and pins meet their own lines
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 500 && i < 600);
      p = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      send_word(p, 4'($urandom_range(0, 15)), $urandom_range(0, 99) < 55,
                2'($urandom_range(0, 3)));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LINES_PER_GROUP + 8) @(posedge clk);

    $display("sent %0d requests, checked %0d words, %0d refused for a full group",
             words_sent, results_seen, full_seen);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    int r;
    out_stall <= 1'b0;
    hold_done = 0;
    wait (!rst);
    forever begin
      r = $urandom_range(0, 99);
      if (!hold_done && words_sent >= 300) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady || r < 40) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 97) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(4, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/pila_pkg.sv
rtl/pila_table.sv
rtl/pila_scan.sv
rtl/pin_interrupt_line_allocator.sv
rtl/pila_checker.sv
test/line_grant_checker.sv
test/pin_interrupt_line_allocator_test.sv
